[src/trickle_retransmit_timer_defines.svh]
// assertion macros for the trickle retransmit timer
`ifndef TRICKLE_RETRANSMIT_TIMER_DEFINES_SVH
`define TRICKLE_RETRANSMIT_TIMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define TRT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TRT_ASSERT(lbl, clk, rstn, prop)
`define TRT_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[src/trt_pkg.sv]
// package for the trickle retransmit timer: payload types, request codes, config indices, defaults
package trt_pkg;
  localparam int NumInstancesDef = 16;
  localparam int PoolBytesDef = 64;

  localparam logic [3:0] ReqTick     = 4'd0;
  localparam logic [3:0] ReqSetTime  = 4'd1;
  localparam logic [3:0] ReqLoadRand = 4'd2;
  localparam logic [3:0] ReqInit     = 4'd3;
  localparam logic [3:0] ReqConsist  = 4'd4;
  localparam logic [3:0] ReqInconsis = 4'd5;
  localparam logic [3:0] ReqReset    = 4'd6;
  localparam logic [3:0] ReqTxDone   = 4'd7;
  localparam logic [3:0] ReqStep     = 4'd8;

  localparam logic [1:0] CfgIntervalMin = 2'd0;
  localparam logic [1:0] CfgCapFactor   = 2'd1;
  localparam logic [1:0] CfgRedundancy  = 2'd2;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [3:0]  instance_index;
    logic [31:0] time_value;
    logic [7:0]  random_byte;
  } req_t;

  typedef struct packed {
    logic        do_tx;
    logic [31:0] next_deadline;
    logic [31:0] current_time;
  } rsp_t;
endpackage

[src/trickle_retransmit_timer.sv]
// top level of the trickle retransmit timer table
//
// Requests enter on req_valid_i/req_stall_o with payload req_i; one response
// per request leaves on rsp_valid_o/rsp_stall_i with payload rsp_o.
// Configuration writes use cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i,
// and are taken only while no request is in flight.
// Requests that do not start an interval pass from StExec to StOut. Interval
// starts (init, reset, accepted inconsistent receive, step at interval end)
// read four pool bytes one per cycle and then, when half the new length is
// not zero, compute the remainder in the shared divider.
// One request at a time; StOut holds the response until the receiver stops
// stalling, and the next request is taken meanwhile only after the response
// has left.
// Reset clears time, pool pointer, the instance table and the pool. The
// pool and the table are cleared by valid bits, so no clearing pass runs.
module trickle_retransmit_timer #(
  parameter int NumInstances = trt_pkg::NumInstancesDef,
  parameter int PoolBytes    = trt_pkg::PoolBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  trt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output trt_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  `include "trickle_retransmit_timer_defines.svh"

  localparam int IW = (NumInstances > 1) ? $clog2(NumInstances) : 1;
  localparam int PW = $clog2(PoolBytes);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StPool = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]  state_q, state_d;
  trt_pkg::req_t req_q;
  logic        in_range;
  logic [IW-1:0] idx;

  logic [15:0] imin_q, capf_q;
  logic [7:0]  red_q;
  logic [31:0] gtime_q;
  logic [PW-1:0] pptr_q;

  logic [31:0] len_r [NumInstances];
  logic [31:0] txp_r [NumInstances];
  logic [31:0] iend_r [NumInstances];
  logic [7:0]  cnt_r [NumInstances];
  logic [NumInstances-1:0] done_r;
  logic [NumInstances-1:0] ivalid_q;

  logic [7:0]  pool_mem [PoolBytes];
  logic [PoolBytes-1:0] pvalid_q;
  logic [7:0]  pool_rd_q;
  logic        pool_rv_q;
  logic [2:0]  pcnt_q;
  logic [31:0] rnd_q;

  logic [31:0] cur_len, cur_txp, cur_iend, new_len, half;
  logic [7:0]  cur_cnt;
  logic        cur_done, tx_q, div_start, div_done;
  logic [31:0] div_rem;
  logic [31:0] cap;

  assign idx      = req_q.instance_index[IW-1:0];
  assign in_range = {28'd0, req_q.instance_index} < 32'(NumInstances);
  assign cur_len  = ivalid_q[idx] ? len_r[idx] : '0;
  assign cur_txp  = ivalid_q[idx] ? txp_r[idx] : '0;
  assign cur_iend = ivalid_q[idx] ? iend_r[idx] : '0;
  assign cur_cnt  = ivalid_q[idx] ? cnt_r[idx] : '0;
  assign cur_done = ivalid_q[idx] & done_r[idx];
  assign half     = {1'b0, new_len[31:1]};
  assign cap      = 32'(imin_q) * 32'(capf_q);

  trt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (half),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  logic start_iv;
  logic [31:0] len_sel;

  assign req_stall_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StOut);
  // all four random bytes are in rnd_q once the pool phase has ended
  assign div_start   = (state_q == StDiv);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (req_valid_i) state_d = StExec;
      StExec: state_d = start_iv ? StPool : StOut;
      StPool: if (pcnt_q == 3'd4) state_d = (half != 0) ? StDiv : StFin;
      StDiv:  state_d = StWait;
      StWait: if (div_done) state_d = StFin;
      StFin:  state_d = StOut;
      StOut:  if (!rsp_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    start_iv = 1'b0;
    len_sel  = cur_len;
    if (in_range) begin
      case (req_q.req_type)
        trt_pkg::ReqInit: begin
          start_iv = 1'b1;
          len_sel  = {15'd0, imin_q, 1'b0};
        end
        trt_pkg::ReqInconsis: if (cur_len > {16'd0, imin_q}) begin
          start_iv = 1'b1;
          len_sel  = {16'd0, imin_q};
        end
        trt_pkg::ReqReset: begin
          start_iv = 1'b1;
          len_sel  = {16'd0, imin_q};
        end
        trt_pkg::ReqStep: if (cur_done && cur_iend <= gtime_q) begin
          start_iv = 1'b1;
          len_sel  = ({cur_len, 1'b0} < {1'b0, cap}) ? {cur_len[30:0], 1'b0} : cap;
        end
        default: start_iv = 1'b0;
      endcase
    end
  end

  // instance update for requests that do not start an interval
  logic       tx_nx;
  logic [7:0] cnt_nx;
  logic       done_nx;
  always_comb begin
    tx_nx   = 1'b0;
    cnt_nx  = cur_cnt;
    done_nx = cur_done;
    case (req_q.req_type)
      trt_pkg::ReqConsist: cnt_nx = (cur_cnt == 8'hFF) ? cur_cnt : cur_cnt + 8'd1;
      trt_pkg::ReqTxDone:  done_nx = 1'b1;
      trt_pkg::ReqStep: if (!cur_done && cur_txp <= gtime_q) begin
        if (cur_cnt < red_q) tx_nx = 1'b1;
        else done_nx = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      imin_q   <= 16'd2;
      capf_q   <= 16'd1;
      red_q    <= 8'd3;
      gtime_q  <= '0;
      pptr_q   <= '0;
      ivalid_q <= '0;
      pvalid_q <= '0;
      pcnt_q   <= '0;
      pool_rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          trt_pkg::CfgIntervalMin: imin_q <= (cfg_data_i < 16'd2) ? 16'd2 : cfg_data_i;
          trt_pkg::CfgCapFactor:   capf_q <= (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
          trt_pkg::CfgRedundancy:  red_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      pool_rv_q <= pvalid_q[pptr_q];
      if (state_q == StExec) begin
        pcnt_q <= '0;
        case (req_q.req_type)
          trt_pkg::ReqTick:    gtime_q <= gtime_q + 32'd1;
          trt_pkg::ReqSetTime: gtime_q <= req_q.time_value;
          trt_pkg::ReqLoadRand: begin
            pvalid_q[pptr_q] <= 1'b1;
            pptr_q <= (pptr_q == PW'(PoolBytes - 1)) ? '0 : pptr_q + PW'(1);
          end
          default: ;
        endcase
        if (in_range && !start_iv) begin
          if (!ivalid_q[idx]) ivalid_q[idx] <= 1'b1;
        end
      end
      if (state_q == StPool && pcnt_q != 3'd4) begin
        pcnt_q <= pcnt_q + 3'd1;
        pptr_q <= (pptr_q == PW'(PoolBytes - 1)) ? '0 : pptr_q + PW'(1);
      end
      if (state_q == StFin) ivalid_q[idx] <= 1'b1;
    end
  end

  // pool write on load, and registered pool read: data arrives in the cycle after its address
  always_ff @(posedge clk_i) begin
    pool_rd_q <= pool_mem[pptr_q];
    if (state_q == StExec && req_q.req_type == trt_pkg::ReqLoadRand)
      pool_mem[pptr_q] <= req_q.random_byte;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i) req_q <= req_i;
    if (state_q == StExec) begin
      tx_q    <= in_range && tx_nx;
      new_len <= len_sel;
      rnd_q   <= '0;
      if (in_range && !start_iv) begin
        if (!ivalid_q[idx]) begin
          len_r[idx] <= '0; txp_r[idx] <= '0; iend_r[idx] <= '0;
        end
        cnt_r[idx]  <= cnt_nx;
        done_r[idx] <= done_nx;
      end
    end
    // byte read in the previous cycle shifts in from the top
    if (state_q == StPool && pcnt_q != 3'd0)
      rnd_q <= {(pool_rv_q ? pool_rd_q : 8'd0), rnd_q[31:8]};
    if (state_q == StFin) begin
      len_r[idx]  <= new_len;
      cnt_r[idx]  <= '0;
      done_r[idx] <= 1'b0;
      iend_r[idx] <= gtime_q + new_len;
      txp_r[idx]  <= gtime_q + half + ((half != 0) ? div_rem : 32'd0);
    end
  end

  always_comb begin
    rsp_o.do_tx = tx_q;
    rsp_o.current_time = gtime_q;
    rsp_o.next_deadline = in_range ? (cur_done ? cur_iend : cur_txp) : 32'd0;
  end

  `TRT_ASSERT(a_one_at_a_time, clk_i, rst_ni, rsp_valid_o |-> req_stall_o)
  `TRT_ASSERT(a_rsp_hold, clk_i, rst_ni, (rsp_valid_o && rsp_stall_i) |=> rsp_valid_o)
  `TRT_ASSERT(a_cfg_idle, clk_i, rst_ni, cfg_ready_o |-> !rsp_valid_o)
endmodule

[src/trt_divider.sv]
// iterative 32-bit remainder unit, one quotient bit per cycle
module trt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, div_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, div_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], quo_q[31]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) div_q <= divisor_i;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

[tb/tb_trickle_retransmit_timer.sv]
// self-checking testbench for the trickle retransmit timer table
module tb_trickle_retransmit_timer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumInst  = 16;
  localparam int PoolSize = 64;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          req_valid_i = 1'b0;
  logic          req_stall_o;
  trt_pkg::req_t req_i = '0;
  logic          rsp_valid_o;
  logic          rsp_stall_i = 1'b0;
  trt_pkg::rsp_t rsp_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [15:0]   cfg_data_i = '0;

  trickle_retransmit_timer uut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // mirror of the timer table
  logic [15:0] t_min = 16'd2;
  logic [15:0] t_factor = 16'd1;
  logic [7:0]  t_redund = 8'd3;
  logic [31:0] t_now = '0;
  logic [7:0]  t_pool [PoolSize];
  logic [5:0]  t_ptr = '0;
  logic [31:0] t_len [NumInst];
  logic [31:0] t_txpt [NumInst];
  logic [31:0] t_end [NumInst];
  logic [7:0]  t_cnt [NumInst];
  logic        t_done [NumInst];

  trt_pkg::req_t pending_reqs[$];
  trt_pkg::rsp_t expected_rsps[$];
  int   n_errors = 0;
  bit   burst_in = 1'b0;
  bit   burst_out = 1'b0;

  initial begin
    for (int i = 0; i < PoolSize; i++) t_pool[i] = '0;
    for (int i = 0; i < NumInst; i++) begin
      t_len[i] = '0; t_txpt[i] = '0; t_end[i] = '0; t_cnt[i] = '0; t_done[i] = 1'b0;
    end
  end

  function automatic logic [7:0] pool_draw();
    logic [7:0] b;
    b = t_pool[t_ptr];
    t_ptr = t_ptr + 6'd1;
    return b;
  endfunction

  function automatic void restart_interval(int i);
    logic [31:0] rnd, half, off;
    t_cnt[i] = '0;
    rnd[7:0] = pool_draw();
    rnd[15:8] = pool_draw();
    rnd[23:16] = pool_draw();
    rnd[31:24] = pool_draw();
    half = t_len[i] >> 1;
    off = (half != 0) ? rnd % half : 32'd0;
    t_txpt[i] = t_now + half + off;
    t_end[i] = t_now + t_len[i];
    t_done[i] = 1'b0;
  endfunction

  function automatic trt_pkg::rsp_t timer_predict(trt_pkg::req_t r);
    trt_pkg::rsp_t e;
    int   i;
    logic [32:0] cap, dbl;
    i = r.instance_index;
    e = '0;
    case (r.req_type)
      trt_pkg::ReqTick:     t_now = t_now + 32'd1;
      trt_pkg::ReqSetTime:  t_now = r.time_value;
      trt_pkg::ReqLoadRand: begin
        t_pool[t_ptr] = r.random_byte;
        t_ptr = t_ptr + 6'd1;
      end
      trt_pkg::ReqInit: begin
        t_len[i] = 32'(t_min) * 2;
        restart_interval(i);
      end
      trt_pkg::ReqConsist: if (t_cnt[i] != 8'hFF) t_cnt[i] = t_cnt[i] + 8'd1;
      trt_pkg::ReqInconsis, trt_pkg::ReqReset: begin
        if (r.req_type == trt_pkg::ReqReset || t_len[i] > 32'(t_min)) begin
          t_len[i] = 32'(t_min);
          restart_interval(i);
        end
      end
      trt_pkg::ReqTxDone: t_done[i] = 1'b1;
      trt_pkg::ReqStep: begin
        if (t_done[i]) begin
          if (t_end[i] <= t_now) begin
            cap = 33'(32'(t_min) * 32'(t_factor));
            dbl = {t_len[i], 1'b0};
            t_len[i] = (dbl < cap) ? dbl[31:0] : cap[31:0];
            restart_interval(i);
          end
        end else if (t_txpt[i] <= t_now) begin
          if (t_cnt[i] < t_redund) e.do_tx = 1'b1;
          else t_done[i] = 1'b1;
        end
      end
      default: ;
    endcase
    e.next_deadline = t_done[i] ? t_end[i] : t_txpt[i];
    e.current_time = t_now;
    return e;
  endfunction

  // request driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (req_valid_i && !req_stall_o) expected_rsps.push_back(timer_predict(req_i));
      if (!(req_valid_i && req_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          req_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_i <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
          if ($urandom_range(0, 29) == 0) burst_in = ~burst_in;
          in_gap = burst_in ? 0 : $urandom_range(0, 18);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor
  int out_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_stall_i <= 1'b0;
      out_wait = 0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("response transfer with nothing outstanding");
          n_errors++;
        end else begin
          trt_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_o.do_tx !== e.do_tx) begin
            $error("do_tx expected %0d got %0d", e.do_tx, rsp_o.do_tx);
            n_errors++;
          end
          if (rsp_o.next_deadline !== e.next_deadline) begin
            $error("next_deadline expected %0h got %0h", e.next_deadline, rsp_o.next_deadline);
            n_errors++;
          end
          if (rsp_o.current_time !== e.current_time) begin
            $error("current_time expected %0h got %0h", e.current_time, rsp_o.current_time);
            n_errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) burst_out = ~burst_out;
        out_wait = burst_out ? 0 : $urandom_range(0, 18);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      rsp_stall_i <= (out_wait != 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      trt_pkg::CfgIntervalMin: t_min = (val < 16'd2) ? 16'd2 : val;
      trt_pkg::CfgCapFactor:   t_factor = (val == 16'd0) ? 16'd1 : val;
      trt_pkg::CfgRedundancy:  t_redund = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void queue_req(logic [3:0] op, logic [3:0] idx,
                                    logic [31:0] tv = '0, logic [7:0] rb = '0);
    trt_pkg::req_t r;
    r.req_type = op;
    r.instance_index = idx;
    r.time_value = tv;
    r.random_byte = rb;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_random(int count);
    int x;
    logic [31:0] tv;
    for (int k = 0; k < count; k++) begin
      x = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: tv = $urandom();
        1: tv = $urandom_range(0, 300);
        default: tv = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      endcase
      if (x < 30) queue_req(trt_pkg::ReqTick, 4'($urandom()));
      else if (x < 34) queue_req(trt_pkg::ReqSetTime, 4'($urandom()), tv);
      else if (x < 44)
        queue_req(trt_pkg::ReqLoadRand, 4'($urandom()), $urandom(), 8'($urandom()));
      else if (x < 51) queue_req(trt_pkg::ReqInit, 4'($urandom()));
      else if (x < 61) queue_req(trt_pkg::ReqConsist, 4'($urandom_range(0, 3)));
      else if (x < 66) queue_req(trt_pkg::ReqInconsis, 4'($urandom()));
      else if (x < 69) queue_req(trt_pkg::ReqReset, 4'($urandom()));
      else if (x < 74) queue_req(trt_pkg::ReqTxDone, 4'($urandom()));
      else if (x < 97) queue_req(trt_pkg::ReqStep, 4'($urandom_range(0, 3)));
      else queue_req(4'($urandom_range(9, 15)), 4'($urandom()), $urandom(), 8'($urandom()));
    end
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: pool extremes, every request, wrap of time, uninitialised instance
    queue_req(trt_pkg::ReqLoadRand, 4'd0, '0, 8'hFF);
    queue_req(trt_pkg::ReqLoadRand, 4'd0, '0, 8'h00);
    queue_req(trt_pkg::ReqLoadRand, 4'd0, '0, 8'hA5);
    queue_req(trt_pkg::ReqLoadRand, 4'd0, '0, 8'h5A);
    queue_req(trt_pkg::ReqTxDone, 4'd9);
    queue_req(trt_pkg::ReqStep, 4'd9);
    queue_req(trt_pkg::ReqInit, 4'd0);
    queue_req(trt_pkg::ReqInit, 4'd15);
    queue_req(trt_pkg::ReqConsist, 4'd0);
    queue_req(trt_pkg::ReqInconsis, 4'd0);
    queue_req(trt_pkg::ReqInconsis, 4'd0);
    queue_req(trt_pkg::ReqTick, 4'd0);
    queue_req(trt_pkg::ReqTick, 4'd0);
    queue_req(trt_pkg::ReqStep, 4'd0);
    queue_req(trt_pkg::ReqTxDone, 4'd0);
    queue_req(trt_pkg::ReqStep, 4'd0);
    queue_req(trt_pkg::ReqReset, 4'd15);
    queue_req(trt_pkg::ReqSetTime, 4'd15, 32'hFFFF_FFFF);
    queue_req(trt_pkg::ReqTick, 4'd15);
    queue_req(trt_pkg::ReqSetTime, 4'd15, 32'hFFFF_FFFF);
    queue_req(trt_pkg::ReqStep, 4'd15);
    queue_req(4'd15, 4'd3, 32'hFFFF_FFFF, 8'hFF);
    queue_req(4'd9, 4'd3);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(trt_pkg::CfgIntervalMin, 16'd0);
          write_reg(trt_pkg::CfgCapFactor, 16'd0);
          write_reg(trt_pkg::CfgRedundancy, 16'd0);
          write_reg(2'd3, 16'($urandom()));
        end
        1: begin
          write_reg(trt_pkg::CfgIntervalMin, 16'hFFFF);
          write_reg(trt_pkg::CfgCapFactor, 16'hFFFF);
          write_reg(trt_pkg::CfgRedundancy, 16'hFFFF);
        end
        2: begin
          write_reg(trt_pkg::CfgIntervalMin, 16'd3);
          write_reg(trt_pkg::CfgCapFactor, 16'd4);
          write_reg(trt_pkg::CfgRedundancy, 16'd1);
        end
        default: begin
          write_reg(trt_pkg::CfgIntervalMin, 16'($urandom_range(1, 24)));
          write_reg(trt_pkg::CfgCapFactor, 16'($urandom_range(0, 9)));
          write_reg(trt_pkg::CfgRedundancy,
                    16'($urandom_range(0, 6)) | 16'($urandom()) << 8);
        end
      endcase
      queue_random(125);
      // saturate one counter once
      if (ph == 2) for (int k = 0; k < 260; k++) queue_req(trt_pkg::ReqConsist, 4'd7);
      drain();
    end

    if (expected_rsps.size() != 0) n_errors++;
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/trt_pkg.sv
src/trt_divider.sv
src/trickle_retransmit_timer.sv
tb/tb_trickle_retransmit_timer.sv
